### src/act_pkg.sv
// ----------------------------------------------------------------------------
// act_pkg
// Shared types and constants for the ambient colour tween.
// ----------------------------------------------------------------------------
package act_pkg;

    localparam int unsigned NCH          = 6;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned MS_PER_SEC   = 1000;
    localparam int unsigned MAX_MS_FIELD = 59;
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam logic [10:0] HW_RESET     = 11'd1200;
    localparam logic [7:0]  RATE_RESET   = 8'd64;
    localparam int unsigned DIV_DW       = 12;

    // Division by 1000 of a 24-bit product: drop three bits, then multiply by
    // ceil(2^28 / 125) and keep the bits from 28 upwards.
    localparam logic [21:0] STEP_RECIP   = 22'd2147484;

    // Register offsets on the configuration port
    localparam logic REG_HALF_WINDOW = 1'b0;
    localparam logic REG_EASE_RATE   = 1'b1;

    // Kind field codes
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_SET     = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SET,
        OP_TICK,
        OP_REJECT
    } t_op;

    typedef enum logic [1:0] {
        MODE_FLAT,
        MODE_PREV,
        MODE_NEXT
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CUR,
        ST_RD_NB,
        ST_STEP,
        ST_STEP_W,
        ST_CH,
        ST_CH_W,
        ST_EASE,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [15:0] elapsed_ms;
    } t_ctl;

endpackage

### src/act_ram.sv
// ----------------------------------------------------------------------------
// act_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module act_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/act_div.sv
// ----------------------------------------------------------------------------
// act_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module act_div #(
    parameter int unsigned PW = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [PW-1:0]             i_dividend,
    input  logic [act_pkg::DIV_DW-1:0] i_divisor,
    output logic                      o_done,
    output logic [PW-1:0]             o_quot
);
    import act_pkg::*;

    localparam int unsigned CNTW = $clog2(PW);

    logic [PW-1:0]     r_q, n_q;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_DW-1:0] r_div;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_DW:0]   t_try;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        t_try  = {r_rem, r_q[PW-1]};
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_cnt  = CNTW'(PW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (t_try >= {1'b0, r_div}) begin
                n_rem = DIV_DW'(t_try - {1'b0, r_div});
                n_q   = {r_q[PW-2:0], 1'b1};
            end else begin
                n_rem = t_try[DIV_DW-1:0];
                n_q   = {r_q[PW-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### src/act_front.sv
// ----------------------------------------------------------------------------
// act_front
// Accepts input transactions, classifies them and holds them in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module act_front #(
    parameter int unsigned HOURS_PER_DAY = 24,
    parameter int unsigned CHANNEL_BITS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_kind,
    input  logic [4:0]                       i_hour,
    input  logic [5:0]                       i_minute,
    input  logic [5:0]                       i_second,
    input  logic [15:0]                      i_elapsed_ms,
    input  logic [act_pkg::NCH*CHANNEL_BITS-1:0] i_rgb,
    output logic                             o_valid,
    input  logic                             i_pop,
    output act_pkg::t_ctl                    o_ctl,
    output logic [act_pkg::NCH*CHANNEL_BITS-1:0] o_rgb,
    output logic [1:0]                       o_count
);
    import act_pkg::*;

    localparam int unsigned CW = NCH * CHANNEL_BITS;

    t_ctl          r_ctl [2];
    logic [CW-1:0] r_rgb [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          t_push;
    t_op           t_class;

    always_comb begin
        if ({2'b00, i_hour} >= 7'(HOURS_PER_DAY)) begin
            t_class = OP_REJECT;
        end else begin
            case (i_kind)
                KIND_LOAD: t_class = OP_LOAD;
                KIND_SET:  t_class = OP_SET;
                KIND_TICK: t_class = OP_TICK;
                default:   t_class = OP_REJECT;
            endcase
        end
    end

    assign o_ready = (r_cnt != 2'd2);
    assign t_push  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (t_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, t_push} - {1'b0, i_pop};
        end
        if (t_push) begin
            r_ctl[r_wp] <= '{op: t_class, hour: i_hour, minute: i_minute,
                             second: i_second, elapsed_ms: i_elapsed_ms};
            r_rgb[r_wp] <= i_rgb;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_ctl   = r_ctl[r_rp];
    assign o_rgb   = r_rgb[r_rp];
    assign o_count = r_cnt;
endmodule

### src/act_back.sv
// ----------------------------------------------------------------------------
// act_back
// Executes queued items: table access, crossfade through a shared divider,
// easing, change detection and the result register.
// ----------------------------------------------------------------------------
module act_back #(
    parameter int unsigned HOURS_PER_DAY = 24,
    parameter int unsigned CHANNEL_BITS  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [10:0]                          i_half_window,
    input  logic [7:0]                           i_ease_rate,
    input  logic                                 i_valid,
    output logic                                 o_pop,
    input  act_pkg::t_ctl                        i_ctl,
    input  logic [act_pkg::NCH*CHANNEL_BITS-1:0] i_rgb,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_accepted,
    output logic                                 o_relight,
    output logic [act_pkg::NCH*CHANNEL_BITS-1:0] o_rgb
);
    import act_pkg::*;

    localparam int unsigned CB = CHANNEL_BITS;
    localparam int unsigned CW = NCH * CB;
    localparam int unsigned HW = (HOURS_PER_DAY > 1) ? $clog2(HOURS_PER_DAY) : 1;
    localparam int unsigned PW = (CB + DIV_DW > 24) ? CB + DIV_DW : 24;

    t_state           r_state, n_state;
    t_op              r_op;
    t_mode            r_mode;
    logic [HW-1:0]    r_nb_idx;
    logic [11:0]      r_num, r_den;
    logic [15:0]      r_ms;
    logic [23:0]      r_prod;
    logic [14:0]      r_step;
    logic [2:0]       r_ch;
    logic             r_neg;
    logic [CB-1:0]    r_tgt;
    logic [CW-1:0]    r_cur, r_nb, r_app, r_last;
    logic             r_cache;
    logic [HOURS_PER_DAY-1:0] r_vld;
    logic             r_vq;
    logic             r_o_valid, r_o_acc, r_o_rl;
    logic [CW-1:0]    r_o_rgb;

    // Datapath helpers
    logic [HW-1:0]    t_hidx, t_prev, t_next, t_raddr;
    logic [5:0]       t_min, t_sec;
    logic [11:0]      t_s;
    logic [12:0]      t_sw;
    logic             t_pop;
    logic             t_we;
    logic [CW-1:0]    t_rdata, t_rd_ok;
    logic             t_div_start;
    logic [PW-1:0]    t_div_in, t_quot;
    logic [DIV_DW-1:0] t_div_den;
    logic             t_div_done;
    logic [CB-1:0]    t_lo, t_hi, t_cur_ch, t_new;
    logic [CB:0]      t_diff;
    logic [CB-1:0]    t_mag;
    logic [16:0]      t_gap, t_step17;
    logic [42:0]      t_recip;

    assign t_hidx  = HW'(i_ctl.hour);
    assign t_prev  = (t_hidx == '0) ? HW'(HOURS_PER_DAY - 1) : t_hidx - 1'b1;
    assign t_next  = (t_hidx == HW'(HOURS_PER_DAY - 1)) ? '0 : t_hidx + 1'b1;
    assign t_min   = (i_ctl.minute > 6'(MAX_MS_FIELD)) ? 6'(MAX_MS_FIELD) : i_ctl.minute;
    assign t_sec   = (i_ctl.second > 6'(MAX_MS_FIELD)) ? 6'(MAX_MS_FIELD) : i_ctl.second;
    assign t_s     = 12'(t_min * 12'(SEC_PER_MIN)) + {6'b0, t_sec};
    assign t_sw    = {1'b0, t_s} + {2'b0, i_half_window};
    assign t_pop   = (r_state == ST_IDLE) && i_valid && !r_o_valid;
    assign o_pop   = t_pop;
    assign t_we    = t_pop && (i_ctl.op == OP_LOAD);
    assign t_raddr = (r_state == ST_RD_CUR) ? r_nb_idx : t_hidx;
    assign t_rd_ok = r_vq ? t_rdata : '0;

    // Easing step: elapsed_ms * ease_rate / 1000 by reciprocal multiplication.
    assign t_recip = r_prod[23:3] * STEP_RECIP;

    act_ram #(.WIDTH(CW), .DEPTH(HOURS_PER_DAY)) u_table (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_hidx),
        .i_wdata (i_rgb),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    act_div #(.PW(PW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (t_div_start),
        .i_dividend (t_div_in),
        .i_divisor  (t_div_den),
        .o_done     (t_div_done),
        .o_quot     (t_quot)
    );

    // Channel selection for the crossfade and easing steps
    always_comb begin
        t_cur_ch = r_app[r_ch*CB +: CB];
        if (r_mode == MODE_PREV) begin
            t_lo = r_nb[r_ch*CB +: CB];
            t_hi = r_cur[r_ch*CB +: CB];
        end else begin
            t_lo = r_cur[r_ch*CB +: CB];
            t_hi = r_nb[r_ch*CB +: CB];
        end
        t_diff   = {1'b0, t_hi} - {1'b0, t_lo};
        t_mag    = t_diff[CB] ? CB'(-t_diff) : t_diff[CB-1:0];
        t_step17 = 17'(r_step);
        if (!r_cache || t_cur_ch == r_tgt) begin
            t_new = r_tgt;
            t_gap = '0;
        end else if (t_cur_ch < r_tgt) begin
            t_gap = 17'(r_tgt - t_cur_ch);
            t_new = (t_gap > t_step17) ? t_cur_ch + CB'(r_step) : r_tgt;
        end else begin
            t_gap = 17'(t_cur_ch - r_tgt);
            t_new = (t_gap > t_step17) ? t_cur_ch - CB'(r_step) : r_tgt;
        end
    end

    always_comb begin
        n_state     = r_state;
        t_div_start = 1'b0;
        t_div_in    = PW'(t_mag * r_num);
        t_div_den   = r_den;
        case (r_state)
            ST_IDLE: begin
                if (t_pop && (i_ctl.op == OP_SET || i_ctl.op == OP_TICK)) begin
                    n_state = ST_RD_CUR;
                end
            end
            ST_RD_CUR: begin
                if (r_op == OP_SET) begin
                    n_state = ST_IDLE;
                end else if (r_mode == MODE_FLAT) begin
                    n_state = ST_STEP;
                end else begin
                    n_state = ST_RD_NB;
                end
            end
            ST_RD_NB:  n_state = ST_STEP;
            ST_STEP:   n_state = ST_STEP_W;
            ST_STEP_W: n_state = ST_CH;
            ST_CH: begin
                if (r_mode == MODE_FLAT) begin
                    n_state = ST_EASE;
                end else begin
                    t_div_start = 1'b1;
                    n_state     = ST_CH_W;
                end
            end
            ST_CH_W: begin
                if (t_div_done) begin
                    n_state = ST_EASE;
                end
            end
            ST_EASE: n_state = (r_ch == 3'(NCH - 1)) ? ST_FIN : ST_CH;
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cache   <= 1'b0;
            r_vld     <= '0;
            r_app     <= '0;
            r_last    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (t_pop) begin
                        if (i_ctl.op == OP_LOAD) begin
                            r_vld[t_hidx] <= 1'b1;
                        end
                        if (i_ctl.op == OP_LOAD || i_ctl.op == OP_REJECT) begin
                            r_o_valid <= 1'b1;
                            r_o_acc   <= (i_ctl.op == OP_LOAD);
                            r_o_rl    <= 1'b0;
                            r_o_rgb   <= r_app;
                        end
                    end
                end
                ST_RD_CUR: begin
                    if (r_op == OP_SET) begin
                        r_cache   <= 1'b0;
                        r_o_valid <= 1'b1;
                        r_o_acc   <= 1'b1;
                        r_o_rl    <= 1'b1;
                        r_o_rgb   <= t_rd_ok;
                    end
                end
                ST_EASE: begin
                    r_app[r_ch*CB +: CB] <= t_new;
                end
                ST_FIN: begin
                    r_o_valid <= 1'b1;
                    r_o_acc   <= 1'b1;
                    r_o_rgb   <= r_app;
                    if (r_cache && r_app == r_last) begin
                        r_o_rl <= 1'b0;
                    end else begin
                        r_o_rl  <= 1'b1;
                        r_cache <= 1'b1;
                        r_last  <= r_app;
                    end
                end
                default: ;
            endcase
        end
        r_vq <= r_vld[t_raddr];
        if (t_pop) begin
            r_op     <= i_ctl.op;
            r_ms     <= i_ctl.elapsed_ms;
            r_den    <= {i_half_window, 1'b0};
            if (i_half_window != '0 && t_s < {1'b0, i_half_window}) begin
                r_mode   <= MODE_PREV;
                r_num    <= t_sw[11:0];
                r_nb_idx <= t_prev;
            end else if (i_half_window != '0 && t_sw > 13'(SEC_PER_HOUR)) begin
                r_mode   <= MODE_NEXT;
                r_num    <= 12'(t_sw - 13'(SEC_PER_HOUR));
                r_nb_idx <= t_next;
            end else begin
                r_mode   <= MODE_FLAT;
                r_num    <= '0;
                r_nb_idx <= t_hidx;
            end
        end
        if (r_state == ST_RD_CUR) begin
            r_cur <= t_rd_ok;
        end
        if (r_state == ST_RD_NB) begin
            r_nb <= t_rd_ok;
        end
        if (r_state == ST_STEP) begin
            r_prod <= {8'b0, r_ms} * {16'b0, i_ease_rate};
        end
        if (r_state == ST_STEP_W) begin
            r_step <= (t_recip[42:28] == '0) ? 15'd1 : t_recip[42:28];
            r_ch   <= '0;
        end
        if (r_state == ST_CH) begin
            r_neg <= t_diff[CB];
            if (r_mode == MODE_FLAT) begin
                r_tgt <= r_cur[r_ch*CB +: CB];
            end
        end
        if (r_state == ST_CH_W && t_div_done) begin
            r_tgt <= r_neg ? t_lo - t_quot[CB-1:0] : t_lo + t_quot[CB-1:0];
        end
        if (r_state == ST_EASE) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_accepted = r_o_acc;
    assign o_relight  = r_o_rl;
    assign o_rgb      = r_o_rgb;
endmodule

### src/ambient_color_time_tween.sv
// ----------------------------------------------------------------------------
// ambient_color_time_tween
// Time-of-day ambient colour tween: hourly set-point table, crossfade near
// hour boundaries, easing of the applied colours and relight detection.
// ----------------------------------------------------------------------------
//
// Channel      Direction  Handshake            Payload
// s (items)    in         i_s_tvalid/o_s_tready i_s_tuser kind, i_s_tdata fields
// m (results)  out        o_m_tvalid/i_m_tready o_m_tuser flags, o_m_tdata colours
// cfg (APB)    in         psel/penable/pready   two registers at 0x0 and 0x4
//
// A load or rejected item gets its result from the idle state, a set-hour item
// after the current-hour table read. For a tick on the flat part of an hour
// the easing step comes from a reciprocal multiplication, then each of the six
// channels passes through a channel and an ease state. Inside a crossfade each
// channel also waits on the shared restoring divider.
// Reset is synchronous and empties the table valid bits, the change cache and
// the applied colours at once; no clearing pass is needed.
// The front queue holds two transactions, so input is accepted while a
// result waits on a stalled output; the back end starts the next item only
// once the result register is free.
// ----------------------------------------------------------------------------
module ambient_color_time_tween #(
    parameter int unsigned HOURS_PER_DAY = 24,
    parameter int unsigned CHANNEL_BITS  = 8,
    localparam int unsigned IN_W  = ((33 + 6 * CHANNEL_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((6 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input stream
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // tdata from bit 0: hour, minute, second, elapsed_ms, in_red_in,
    // in_green_in, in_blue_in, out_red_in, out_green_in, out_blue_in, zeros
    input  logic [IN_W-1:0]  i_s_tdata,
    // tuser: kind
    input  logic [1:0]       i_s_tuser,
    // Result stream
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // tdata from bit 0: in_red_out, in_green_out, in_blue_out, out_red_out,
    // out_green_out, out_blue_out, zeros
    output logic [OUT_W-1:0] o_m_tdata,
    // tuser from bit 0: accepted, relight
    output logic [1:0]       o_m_tuser,
    // Configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import act_pkg::*;

    localparam int unsigned CW = NCH * CHANNEL_BITS;

    logic [10:0]   r_half_window;
    logic [7:0]    r_ease_rate;
    logic          q_valid, q_pop;
    t_ctl          q_ctl;
    logic [CW-1:0] q_rgb, m_rgb;
    logic [1:0]    q_count;
    logic          m_acc, m_rl;

    // Register writes complete in the APB access phase.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= HW_RESET;
            r_ease_rate   <= RATE_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_HALF_WINDOW: r_half_window <= pwdata[10:0];
                REG_EASE_RATE:   r_ease_rate   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HALF_WINDOW: prdata = {21'b0, r_half_window};
            REG_EASE_RATE:   prdata = {24'b0, r_ease_rate};
            default:         prdata = '0;
        endcase
    end

    // The front end classifies each transaction and queues it.
    act_front #(.HOURS_PER_DAY(HOURS_PER_DAY), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_kind       (i_s_tuser),
        .i_hour       (i_s_tdata[4:0]),
        .i_minute     (i_s_tdata[10:5]),
        .i_second     (i_s_tdata[16:11]),
        .i_elapsed_ms (i_s_tdata[32:17]),
        .i_rgb        (i_s_tdata[33 +: CW]),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_ctl        (q_ctl),
        .o_rgb        (q_rgb),
        .o_count      (q_count)
    );

    // The back end owns the table, the divider and the result register.
    act_back #(.HOURS_PER_DAY(HOURS_PER_DAY), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_window (r_half_window),
        .i_ease_rate   (r_ease_rate),
        .i_valid       (q_valid),
        .o_pop         (q_pop),
        .i_ctl         (q_ctl),
        .i_rgb         (q_rgb),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_accepted    (m_acc),
        .o_relight     (m_rl),
        .o_rgb         (m_rgb)
    );

    assign o_m_tdata = OUT_W'(m_rgb);
    assign o_m_tuser = {m_rl, m_acc};

    // A rejected item never pushes new colours.
    a_rl_needs_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] || !o_m_tuser[1]))
        else $error("relight flagged on a rejected item");

    // The back end only takes an item from a non-empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_count != 2'd0))
        else $error("queue popped while empty");

    // The queue never claims more than its two entries.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count != 2'd3)
        else $error("queue count overflow");

    // Taking an item means the result register was free for it.
    a_pop_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !o_m_tvalid)
        else $error("item started with a result still pending");
endmodule

### sim/ambient_color_time_tween_tb.sv
// ----------------------------------------------------------------------------
// ambient_color_time_tween_tb
// Self-checking bench for the ambient colour tween: a colour predictor built
// from the table, crossfade and easing rules is compared against every result.
// ----------------------------------------------------------------------------
module ambient_color_time_tween_tb;
    import act_pkg::*;

    localparam int unsigned HOURS = 24;
    localparam int unsigned IN_W  = 88;
    localparam int unsigned OUT_W = 48;

    typedef logic [7:0] t_chan;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [15:0] elapsed_ms;
        t_chan [5:0] colour;   // element 0 is indoor red
    } t_item;

    typedef struct packed {
        logic        accepted;
        logic        relight;
        t_chan [5:0] colour;
    } t_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    // tdata from bit 0: hour, minute, second, elapsed_ms, six set-points, zeros
    logic [IN_W-1:0]  i_s_tdata;
    // tuser: kind
    logic [1:0]       i_s_tuser;
    logic             o_m_tvalid;
    logic             i_m_tready;
    // tdata from bit 0: six applied channels
    logic [OUT_W-1:0] o_m_tdata;
    // tuser from bit 0: accepted, relight
    logic [1:0]       o_m_tuser;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    ambient_color_time_tween uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state, mirroring the block's own.
    t_chan [5:0] setpoints [HOURS];
    t_chan [5:0] applied;
    t_chan [5:0] last_pushed;
    logic        cache_ok;
    int unsigned half_window;
    int unsigned ease_rate;

    t_result pending_results[$];
    int      failures;
    bit      idle_enabled;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous guard: ~2000 items, plus stalls.
    initial begin
        #4000000;
        $display("ambient_color_time_tween: mismatch");
        $finish;
    end

    function automatic t_chan blend(t_chan lo, t_chan hi, int num, int den);
        int d;
        d = (int'(hi) - int'(lo)) * num / den;   // SV int division truncates toward zero
        return t_chan'(int'(lo) + d);
    endfunction

    function automatic t_chan ease(t_chan cur, t_chan tgt, int unsigned step);
        if (cur < tgt) return (tgt - cur > step) ? t_chan'(cur + step) : tgt;
        if (cur > tgt) return (cur - tgt > step) ? t_chan'(cur - step) : tgt;
        return cur;
    endfunction

    // Works out the result of one item and updates the predictor state.
    function automatic t_result predict_colours(t_item it);
        t_result     r;
        t_chan [5:0] tgt;
        int          s, w;
        int unsigned m, sec, step, prv, nxt;
        r.accepted = 1'b0;
        r.relight  = 1'b0;
        r.colour   = applied;
        if (it.kind == KIND_IGNORED || it.hour >= HOURS) return r;
        r.accepted = 1'b1;
        if (it.kind == KIND_LOAD) begin
            setpoints[it.hour] = it.colour;
            return r;
        end
        if (it.kind == KIND_SET) begin
            cache_ok = 1'b0;
            r.relight = 1'b1;
            r.colour = setpoints[it.hour];
            return r;
        end
        m   = (it.minute > 59) ? 59 : it.minute;
        sec = (it.second > 59) ? 59 : it.second;
        s   = m * SEC_PER_MIN + sec;
        w   = half_window;
        prv = (it.hour + HOURS - 1) % HOURS;
        nxt = (it.hour + 1) % HOURS;
        for (int i = 0; i < 6; i++) begin
            if (w > 0 && s < w)
                tgt[i] = blend(setpoints[prv][i], setpoints[it.hour][i], w + s, 2 * w);
            else if (w > 0 && s > int'(SEC_PER_HOUR) - w)
                tgt[i] = blend(setpoints[it.hour][i], setpoints[nxt][i],
                               s - int'(SEC_PER_HOUR) + w, 2 * w);
            else
                tgt[i] = setpoints[it.hour][i];
        end
        if (!cache_ok) begin
            applied = tgt;
        end else begin
            step = it.elapsed_ms * ease_rate / MS_PER_SEC;
            if (step < 1) step = 1;
            for (int i = 0; i < 6; i++) applied[i] = ease(applied[i], tgt[i], step);
        end
        r.colour = applied;
        if (cache_ok && applied == last_pushed) return r;
        cache_ok    = 1'b1;
        last_pushed = applied;
        r.relight   = 1'b1;
        return r;
    endfunction

    // Sends one item; the prediction is queued when the transaction completes.
    // tvalid stays high afterwards until the next item or a drain lowers it.
    task automatic send_item(t_item it);
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.kind;
        i_s_tdata  <= {it.colour, it.elapsed_ms, it.second, it.minute, it.hour};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(predict_colours(it));
    endtask

    // Result checker, with random back-pressure in bursts.
    initial begin
        t_result exp_r, got;
        int      stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_m_tready && o_m_tvalid) begin
                got.accepted = o_m_tuser[0];
                got.relight  = o_m_tuser[1];
                got.colour   = o_m_tdata;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    failures++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.accepted !== exp_r.accepted)
                        $display("%0t: accepted expected %b actual %b",
                                 $time, exp_r.accepted, got.accepted);
                    if (got.relight !== exp_r.relight)
                        $display("%0t: relight expected %b actual %b",
                                 $time, exp_r.relight, got.relight);
                    for (int i = 0; i < 6; i++)
                        if (got.colour[i] !== exp_r.colour[i])
                            $display("%0t: channel %0d expected %h actual %h",
                                     $time, i, exp_r.colour[i], got.colour[i]);
                    if (got !== exp_r) failures++;
                end
            end
            if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 3) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_register(logic reg_index, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == REG_HALF_WINDOW) half_window = value & 11'h7FF;
        else ease_rate = value & 8'hFF;
        @(posedge i_clk);
    endtask

    function automatic t_item random_item(logic [1:0] kind, bit wild);
        t_item it;
        it.kind       = kind;
        it.hour       = wild ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, HOURS - 1));
        it.minute     = 6'($urandom);
        it.second     = 6'($urandom);
        it.elapsed_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
        for (int i = 0; i < 6; i++) it.colour[i] = t_chan'($urandom);
        return it;
    endfunction

    function automatic t_item make_item(logic [1:0] kind, int hr, int mn, int sc, int ms);
        t_item it;
        it = random_item(kind, 1'b0);
        it.hour = 5'(hr); it.minute = 6'(mn); it.second = 6'(sc); it.elapsed_ms = 16'(ms);
        return it;
    endfunction

    // Fill the table, including the extreme set-points.
    task automatic test_table_load();
        t_item it;
        for (int h = 0; h < HOURS; h++) begin
            it = random_item(KIND_LOAD, 1'b0);
            it.hour = 5'(h);
            if (h == 0) it.colour = '0;
            if (h == 23) it.colour = '1;
            send_item(it);
        end
    endtask

    // Set-hour, rejected hours, kind three, clamping and window edges.
    task automatic test_directed();
        send_item(make_item(KIND_SET, 0, 0, 0, 0));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0));       // snap, blend from hour 23
        send_item(make_item(KIND_TICK, 0, 63, 63, 65535));  // clamped, next-hour blend
        send_item(make_item(KIND_TICK, 12, 30, 0, 0));      // flat, smallest step
        send_item(make_item(KIND_TICK, 12, 30, 0, 0));      // same flat tick again
        send_item(make_item(KIND_TICK, 24, 0, 0, 0));
        send_item(make_item(KIND_LOAD, 31, 0, 0, 0));
        send_item(make_item(KIND_SET, 25, 0, 0, 0));
        send_item(make_item(KIND_IGNORED, 5, 0, 0, 0));
        send_item(make_item(KIND_TICK, 23, 59, 59, 1000));
        wait_drained();
    endtask

    // Window and rate extremes, including blending disabled and overlapping windows.
    task automatic test_config_sweep();
        int unsigned windows [4] = '{0, 1800, 2047, 1};
        int unsigned rates   [4] = '{0, 255, 1, 64};
        for (int k = 0; k < 4; k++) begin
            write_register(REG_HALF_WINDOW, windows[k]);
            write_register(REG_EASE_RATE, rates[k]);
            send_item(make_item(KIND_SET, k, 0, 0, 0));
            for (int n = 0; n < 30; n++)
                send_item(random_item(KIND_TICK, 1'b0));
            wait_drained();
        end
    endtask

    // Mostly set-hour then tick runs, with reloads and some noise.
    task automatic test_random(int count, int max_window);
        int    sel;
        t_item it;
        for (int n = 0; n < count; n++) begin
            if (n % 300 == 299) begin
                wait_drained();
                write_register(REG_HALF_WINDOW, $urandom_range(0, max_window));
                write_register(REG_EASE_RATE, $urandom_range(0, 255));
            end
            sel = $urandom_range(0, 99);
            if (sel < 8)       it = random_item(KIND_LOAD, 1'b0);
            else if (sel < 14) it = random_item(KIND_SET, 1'b0);
            else if (sel < 18) it = random_item(2'($urandom), 1'b1);
            else               it = random_item(KIND_TICK, 1'b0);
            send_item(it);
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tuser = '0;
        i_m_tready = 1'b1; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        setpoints = '{default: '0};
        applied = '0; last_pushed = '0; cache_ok = 1'b0;
        half_window = HW_RESET; ease_rate = RATE_RESET;
        failures = 0; idle_enabled = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_load();
        test_directed();
        test_config_sweep();
        test_random(1340, 2047);
        wait_drained();
        idle_enabled = 1'b0;
        test_random(300, 1800);
        wait_drained();
        if (failures == 0) begin
            $display("ambient_color_time_tween: match");
        end else begin
            $display("ambient_color_time_tween: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
src/act_pkg.sv
src/act_ram.sv
src/act_div.sv
src/act_front.sv
src/act_back.sv
src/ambient_color_time_tween.sv
sim/ambient_color_time_tween_tb.sv
